// File: hw/rtl/binary_to_decimal_ascii_formatter_top_assert.svh
// assertion helpers for the formatter checker
`ifndef BINARY_TO_DECIMAL_ASCII_FORMATTER_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_FORMATTER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define B2DA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/b2da_pkg.sv
`default_nettype none
package b2da_pkg;

  typedef enum logic [2:0] {
    CMD_SIGNED = 3'd0,
    CMD_TWO    = 3'd1,
    CMD_BYTE   = 3'd2,
    CMD_HALF   = 3'd3,
    CMD_WORD   = 3'd4
  } cmd_e;

  localparam int unsigned NUM_POW = 10;
  localparam int unsigned KW      = $clog2(NUM_POW);

  localparam logic [31:0] POW10 [NUM_POW] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_MINUS = 7'd45;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_beat_t;

  // one classified job for the digit engine
  typedef struct packed {
    logic          neg;
    logic [KW-1:0] start_k;
    logic [KW-1:0] emit_k;
    logic [31:0]   mag;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_src_t;

endpackage
`default_nettype wire

// File: hw/rtl/binary_to_decimal_ascii_formatter_top.sv
// Binary to decimal ASCII formatter. Each input beat carries a mode (cmd) and a
// 32-bit value; the block answers with a fixed count of ASCII digits, leading
// zeros kept, most significant first, one character per output beat, and
// raises last on the final character. Mode 0 reads the low halfword as two's
// complement, sends '-' for a negative value, then four digits of the
// magnitude mod 10000; mode 1 sends two digits, mode 2 three digits of the low
// byte, mode 3 five digits of the low halfword, mode 4 ten digits of the word.
// Modes 5 to 7 are accepted and produce nothing. The digit engine yields one
// decimal digit per cycle unless the output is stalled, by comparing the
// remainder against all nine multiples of the current power of ten at once;
// it walks ten digits for mode 4, five for mode 3, three for mode 2, five for
// mode 1 (three high digits are walked and dropped) and five for mode 0, plus
// a step for the minus sign. A two-entry job queue sits between the input
// classifier and the engine; the output register takes a new character in the
// cycle its old one leaves, so a stall on either side does not stop the other.
`default_nettype none
module binary_to_decimal_ascii_formatter_top (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire  b2da_pkg::in_beat_t   in_beat_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output b2da_pkg::out_beat_t        out_beat_o
);

  logic               fifo_full;
  logic               push;
  logic               pop;
  logic               in_fire;
  b2da_pkg::job_t     job;
  b2da_pkg::job_src_t head;

  // input stalls only while the job queue is full
  assign in_stall_o = fifo_full;
  assign in_fire    = in_valid_i & ~fifo_full;

  // classify: mask, sign, digit window
  b2da_front u_front (
    .in_beat_i (in_beat_i),
    .in_fire_i (in_fire),
    .push_o    (push),
    .job_o     (job)
  );

  // decouples the classifier from the digit engine
  b2da_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .full_o (fifo_full),
    .head_o (head)
  );

  // digit engine and output register
  b2da_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire

// File: hw/rtl/b2da_front.sv
`default_nettype none
module b2da_front (
  input  wire  b2da_pkg::in_beat_t in_beat_i,
  input  wire                      in_fire_i,
  output logic                     push_o,
  output b2da_pkg::job_t           job_o
);

  logic [15:0] half;
  logic [16:0] neg_mag;
  logic        known;

  assign half    = in_beat_i.value[15:0];
  assign neg_mag = 17'h10000 - {1'b0, half};

  always_comb begin
    known       = 1'b1;
    job_o.neg   = 1'b0;
    job_o.mag   = in_beat_i.value;
    job_o.start_k = '0;
    job_o.emit_k  = '0;
    case (in_beat_i.cmd)
      b2da_pkg::CMD_SIGNED: begin
        // five digit walk, top digit dropped gives the mod 10000
        job_o.neg     = half[15];
        job_o.mag     = half[15] ? {15'd0, neg_mag} : {16'd0, half};
        job_o.start_k = b2da_pkg::KW'(4);
        job_o.emit_k  = b2da_pkg::KW'(3);
      end
      b2da_pkg::CMD_TWO: begin
        job_o.mag     = {16'd0, half};
        job_o.start_k = b2da_pkg::KW'(4);
        job_o.emit_k  = b2da_pkg::KW'(1);
      end
      b2da_pkg::CMD_BYTE: begin
        job_o.mag     = {24'd0, in_beat_i.value[7:0]};
        job_o.start_k = b2da_pkg::KW'(2);
        job_o.emit_k  = b2da_pkg::KW'(2);
      end
      b2da_pkg::CMD_HALF: begin
        job_o.mag     = {16'd0, half};
        job_o.start_k = b2da_pkg::KW'(4);
        job_o.emit_k  = b2da_pkg::KW'(4);
      end
      b2da_pkg::CMD_WORD: begin
        job_o.start_k = b2da_pkg::KW'(9);
        job_o.emit_k  = b2da_pkg::KW'(9);
      end
      default: known = 1'b0;
    endcase
  end

  // unused modes are swallowed here
  assign push_o = in_fire_i & known;

endmodule
`default_nettype wire

// File: hw/rtl/b2da_fifo.sv
`default_nettype none
module b2da_fifo (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       push_i,
  input  wire  b2da_pkg::job_t      job_i,
  input  wire                       pop_i,
  output logic                      full_o,
  output b2da_pkg::job_src_t        head_o
);

  localparam int unsigned PW = $clog2(b2da_pkg::FIFO_DEPTH);
  localparam int unsigned CW = $clog2(b2da_pkg::FIFO_DEPTH + 1);

  b2da_pkg::job_t mem_q [b2da_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(b2da_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign full_o       = (cnt_q == CW'(b2da_pkg::FIFO_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_q];

endmodule
`default_nettype wire

// File: hw/rtl/b2da_back.sv
`default_nettype none
module b2da_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  b2da_pkg::job_src_t   head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output b2da_pkg::out_beat_t        out_beat_o
);

  localparam int unsigned KW = b2da_pkg::KW;

  logic                busy_q, busy_d;
  logic                neg_q, neg_d;
  logic [KW-1:0]       k_q, k_d;
  logic [KW-1:0]       emit_k_q, emit_k_d;
  logic [31:0]         rem_q, rem_d;
  logic                out_valid_q, out_valid_d;
  b2da_pkg::out_beat_t out_beat_q, out_beat_d;

  logic          have, out_ready, suppress, step;
  logic          cur_neg;
  logic [KW-1:0] cur_k, cur_emit_k;
  logic [31:0]   cur_rem;
  logic [33:0]   mult [1:9];
  logic          ge   [1:9];
  logic [31:0]   diff [1:9];
  logic [3:0]    digit;
  logic [31:0]   rem_next;

  assign have      = busy_q | head_i.valid;
  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    if (busy_q) begin
      cur_neg    = neg_q;
      cur_k      = k_q;
      cur_emit_k = emit_k_q;
      cur_rem    = rem_q;
    end else begin
      cur_neg    = head_i.job.neg;
      cur_k      = head_i.job.start_k;
      cur_emit_k = head_i.job.emit_k;
      cur_rem    = head_i.job.mag;
    end
  end

  // d times ten to the k, for every candidate d, compared in parallel
  always_comb begin
    for (int d = 1; d <= 9; d++) begin
      mult[d] = '0;
      for (int k = 0; k < b2da_pkg::NUM_POW; k++) begin
        if (cur_k == KW'(k)) begin
          mult[d] = 34'(d) * {2'b00, b2da_pkg::POW10[k]};
        end
      end
      ge[d]   = ({2'b00, cur_rem} >= mult[d]);
      diff[d] = cur_rem - mult[d][31:0];
    end
  end

  always_comb begin
    digit    = '0;
    rem_next = cur_rem;
    for (int d = 1; d <= 9; d++) begin
      if (ge[d]) begin
        digit    = 4'(d);
        rem_next = diff[d];
      end
    end
  end

  assign suppress = !cur_neg && (cur_k > cur_emit_k);
  assign step     = have && (suppress || out_ready);
  assign pop_o    = step && !busy_q;

  always_comb begin
    busy_d      = busy_q;
    neg_d       = neg_q;
    k_d         = k_q;
    emit_k_d    = emit_k_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_beat_d  = out_beat_q;
    if (step) begin
      emit_k_d = cur_emit_k;
      if (cur_neg) begin
        busy_d               = 1'b1;
        neg_d                = 1'b0;
        k_d                  = cur_k;
        rem_d                = cur_rem;
        out_valid_d          = 1'b1;
        out_beat_d.char_code = b2da_pkg::ASCII_MINUS;
        out_beat_d.last      = 1'b0;
      end else begin
        neg_d  = 1'b0;
        rem_d  = rem_next;
        busy_d = (cur_k != '0);
        k_d    = cur_k - KW'(1);
        if (!suppress) begin
          out_valid_d          = 1'b1;
          out_beat_d.char_code = b2da_pkg::ASCII_ZERO + 7'(digit);
          out_beat_d.last      = (cur_k == '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    emit_k_q   <= emit_k_d;
    rem_q      <= rem_d;
    out_beat_q <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule
`default_nettype wire

// File: hw/rtl/b2da_checker.sv
`default_nettype none
`include "binary_to_decimal_ascii_formatter_top_assert.svh"
module b2da_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      out_valid_o,
  input wire                      out_stall_i,
  input wire b2da_pkg::out_beat_t out_beat_o
);

  `B2DA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "stalled output dropped")
  `B2DA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_beat_o), "stalled output changed")
  `B2DA_ASSERT_SAME(a_char_set, clk_i, rst_ni, out_valid_o, (out_beat_o.char_code == b2da_pkg::ASCII_MINUS) || ((out_beat_o.char_code >= b2da_pkg::ASCII_ZERO) && (out_beat_o.char_code <= b2da_pkg::ASCII_ZERO + 7'd9)), "character is not a digit or minus")
  `B2DA_ASSERT_SAME(a_minus_not_last, clk_i, rst_ni, out_valid_o && (out_beat_o.char_code == b2da_pkg::ASCII_MINUS), !out_beat_o.last, "minus sign marked last")
  `B2DA_ASSERT_NEXT(a_minus_then_digit, clk_i, rst_ni, out_valid_o && !out_stall_i && (out_beat_o.char_code == b2da_pkg::ASCII_MINUS), !out_valid_o || (out_beat_o.char_code != b2da_pkg::ASCII_MINUS), "two minus signs in a row")

endmodule

bind binary_to_decimal_ascii_formatter_top b2da_checker u_b2da_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
`default_nettype wire
